// ----- design/hrss_pkg.sv -----
// Package for the HTTP response status splitter.
// Holds the character constants, the byte classifiers and the parser step type.
// No dependencies.
package hrss_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 32;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned PREFIX_LEN = 5;
  // "HTTP/"
  localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f};

  localparam logic [31:0] CODE_MAX = 32'h7fff_ffff;

  // One byte handed to the status line parser
  typedef struct packed {
    logic       en;          // a byte is consumed this cycle
    logic       last;        // final byte of the response
    logic [7:0] data;
    logic       in_prefix;   // byte position still inside the prefix
    logic [2:0] prefix_idx;  // byte position, valid while in_prefix
  } parse_step_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // space, TAB, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= CHAR_CR));
  endfunction

endpackage

// ----- design/hrss_byte_if.sv -----
// Byte stream channel of the HTTP response status splitter.
// Depends on nothing.
interface hrss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ----- design/hrss_result_if.sv -----
// Result channel of the HTTP response status splitter.
// Depends on nothing.
interface hrss_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] status;
  logic               has_terminator;
  logic [31:0]        header_length;
  logic [31:0]        body_length;

  modport source (output valid, output status, output has_terminator,
                  output header_length, output body_length, input ready);
  modport sink   (input valid, input status, input has_terminator,
                  input header_length, input body_length, output ready);
endinterface

// ----- design/http_response_status_splitter.sv -----
// Top level of the HTTP response status splitter: input stage, terminator
// search, length counters and result register. Depends on hrss_pkg,
// hrss_byte_if, hrss_result_if and hrss_status_parser.
//
//   channel   | direction | payload                                   | transfer
//   byte_i    | in        | data_byte, last                           | per byte
//   result_o  | out       | status, has_terminator, header/body length | per response
//
// One byte per cycle while result_o is not held; a byte waits in the input register
// and is folded into the parse state as it leaves, together with the result register.
// The result register is loaded as the input stage's last byte is consumed.
// Reset is asynchronous and active low and clears all parse state.
// A result that is not taken stalls the input stage and the parse state,
// so byte_i.ready drops only while result_o is held.
module http_response_status_splitter #(
  parameter int unsigned LENGTH_BITS = hrss_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  hrss_byte_if.sink     byte_i,
  hrss_result_if.source result_o
);

  localparam int unsigned LB = LENGTH_BITS;

  // Input stage
  logic       s1_valid_q;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       advance;
  logic       step;

  // Result register
  logic               res_valid_q;
  logic signed [31:0] res_status_q;
  logic               res_term_q;
  logic [31:0]        res_hdr_q;
  logic [31:0]        res_body_q;

  // Scan state
  logic [LB-1:0] pos_q;
  logic [LB-1:0] pos_inc;
  logic [1:0]    crlf_q, crlf_d;
  logic          found_q, found_d;
  logic [LB-1:0] hdr_q, hdr_d;

  logic [LB+1:0]      body_diff;
  logic [LB-1:0]      body_bytes;
  logic [LB+31:0]     hdr_ext;
  logic [LB+31:0]     body_ext;
  logic signed [31:0] status;

  hrss_pkg::parse_step_t pstep;

  assign advance = !(res_valid_q && !result_o.ready);
  assign step    = s1_valid_q && advance;
  assign byte_i.ready = advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && byte_i.valid) begin
      s1_data_q <= byte_i.data_byte;
      s1_last_q <= byte_i.last;
    end
  end

  // Status line parser
  assign pstep.en         = step;
  assign pstep.last       = s1_last_q;
  assign pstep.data       = s1_data_q;
  assign pstep.in_prefix  = (pos_q < LB'(hrss_pkg::PREFIX_LEN));
  assign pstep.prefix_idx = pos_q[2:0];

  hrss_status_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (pstep),
    .status_o (status)
  );

  // Saturating byte position
  assign pos_inc = (pos_q != '1) ? pos_q + LB'(1) : pos_q;

  // First CR LF CR LF search
  always_comb begin
    crlf_d  = crlf_q;
    found_d = found_q;
    hdr_d   = hdr_q;
    if (!found_q) begin
      priority if ((crlf_q == 2'd3) && (s1_data_q == hrss_pkg::CHAR_LF)) begin
        found_d = 1'b1;
        hdr_d   = (pos_q >= LB'(3)) ? pos_q - LB'(3) : '0;
        crlf_d  = 2'd0;
      end else if (s1_data_q == hrss_pkg::CHAR_CR) begin
        crlf_d = (crlf_q == 2'd2) ? 2'd3 : 2'd1;
      end else if ((s1_data_q == hrss_pkg::CHAR_LF) && (crlf_q == 2'd1)) begin
        crlf_d = 2'd2;
      end else begin
        crlf_d = 2'd0;
      end
    end
  end

  // Body length: total - header_end - 4, floored at zero
  assign body_diff  = {2'b00, pos_inc} - {2'b00, hdr_d} - (LB+2)'(4);
  assign body_bytes = body_diff[LB+1] ? '0 : body_diff[LB-1:0];
  assign hdr_ext    = {32'd0, hdr_d};
  assign body_ext   = {32'd0, body_bytes};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crlf_q  <= 2'd0;
      found_q <= 1'b0;
      hdr_q   <= '0;
    end else if (step) begin
      if (s1_last_q) begin
        pos_q   <= '0;
        crlf_q  <= 2'd0;
        found_q <= 1'b0;
        hdr_q   <= '0;
      end else begin
        pos_q   <= pos_inc;
        crlf_q  <= crlf_d;
        found_q <= found_d;
        hdr_q   <= hdr_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= step && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_last_q) begin
      res_status_q <= status;
      res_term_q   <= found_d;
      res_hdr_q    <= found_d ? hdr_ext[31:0] : 32'd0;
      res_body_q   <= found_d ? body_ext[31:0] : 32'd0;
    end
  end

  assign result_o.valid          = res_valid_q;
  assign result_o.status         = res_status_q;
  assign result_o.has_terminator = res_term_q;
  assign result_o.header_length  = res_hdr_q;
  assign result_o.body_length    = res_body_q;

  // Checks
  a_no_term_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_term_q) |-> (res_hdr_q == 32'd0) && (res_body_q == 32'd0))
    else $error("lengths set without a terminator");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (!res_status_q[31] || (res_status_q == '1)))
    else $error("status below -1");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && s1_last_q) |=> (pos_q == '0) && !found_q && (crlf_q == 2'd0))
    else $error("scan state not cleared after final byte");

  a_found_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (crlf_q == 2'd0))
    else $error("match count moving after terminator");

endmodule

// ----- design/hrss_status_parser.sv -----
// Status line parser: checks "HTTP/maj.min " and reads the code strtol style.
// Depends on hrss_pkg.
module hrss_status_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hrss_pkg::parse_step_t step_i,
  output logic signed [31:0]   status_o
);

  localparam logic [3:0] PH_PREFIX      = 4'd0;
  localparam logic [3:0] PH_MAJOR_FIRST = 4'd1;
  localparam logic [3:0] PH_MAJOR       = 4'd2;
  localparam logic [3:0] PH_MINOR_FIRST = 4'd3;
  localparam logic [3:0] PH_MINOR       = 4'd4;
  localparam logic [3:0] PH_SPACE_SKIP  = 4'd5;
  localparam logic [3:0] PH_NEED_DIGIT  = 4'd6;
  localparam logic [3:0] PH_DIGITS      = 4'd7;
  localparam logic [3:0] PH_DONE        = 4'd8;
  localparam logic [3:0] PH_BAD         = 4'd9;

  logic [3:0]  phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic        ovf_q, ovf_d;
  logic        seen_q, seen_d;

  logic [7:0]  c;
  logic        c_digit;
  logic [34:0] acc_x10;
  logic        add_ovf;
  logic [31:0] acc_add;

  assign c       = step_i.data;
  assign c_digit = hrss_pkg::is_digit(c);

  // acc * 10 + digit, overflow when above the code maximum
  assign acc_x10 = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {31'd0, c[3:0]};
  assign add_ovf = ovf_q || (acc_x10 > {3'b000, hrss_pkg::CODE_MAX});
  assign acc_add = add_ovf ? hrss_pkg::CODE_MAX : acc_x10[31:0];

  // Phase and accumulator update
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    seen_d  = seen_q;
    unique case (phase_q)
      PH_PREFIX: begin
        if (step_i.in_prefix && (c == hrss_pkg::PREFIX_TEXT[step_i.prefix_idx])) begin
          phase_d = (step_i.prefix_idx == 3'(hrss_pkg::PREFIX_LEN - 1)) ?
                    PH_MAJOR_FIRST : PH_PREFIX;
        end else begin
          phase_d = PH_BAD;
        end
      end
      PH_MAJOR_FIRST: phase_d = c_digit ? PH_MAJOR : PH_BAD;
      PH_MAJOR: begin
        if (c == hrss_pkg::CHAR_DOT) phase_d = PH_MINOR_FIRST;
        else if (!c_digit)           phase_d = PH_BAD;
      end
      PH_MINOR_FIRST: phase_d = c_digit ? PH_MINOR : PH_BAD;
      PH_MINOR: begin
        if (c == hrss_pkg::CHAR_SPACE) phase_d = PH_SPACE_SKIP;
        else if (!c_digit)             phase_d = PH_BAD;
      end
      PH_SPACE_SKIP: begin
        if (hrss_pkg::is_space(c)) begin
          phase_d = PH_SPACE_SKIP;
        end else if ((c == hrss_pkg::CHAR_PLUS) || (c == hrss_pkg::CHAR_MINUS)) begin
          neg_d   = (c == hrss_pkg::CHAR_MINUS);
          phase_d = PH_NEED_DIGIT;
        end else if (c_digit) begin
          seen_d  = 1'b1;
          ovf_d   = add_ovf;
          acc_d   = acc_add;
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_BAD;
        end
      end
      PH_NEED_DIGIT: begin
        if (c_digit) begin
          seen_d  = 1'b1;
          ovf_d   = add_ovf;
          acc_d   = acc_add;
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (c_digit) begin
          seen_d = 1'b1;
          ovf_d  = add_ovf;
          acc_d  = acc_add;
        end else begin
          phase_d = PH_DONE;
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  // Status as seen after this byte
  always_comb begin
    if (seen_d && !ovf_d && ((phase_d == PH_DIGITS) || (phase_d == PH_DONE)) &&
        (!neg_d || (acc_d == '0))) begin
      status_o = signed'(acc_d);
    end else begin
      status_o = '1;
    end
  end

  // State registers, back to reset values after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else if (step_i.en) begin
      if (step_i.last) begin
        phase_q <= PH_PREFIX;
        acc_q   <= '0;
        neg_q   <= 1'b0;
        ovf_q   <= 1'b0;
        seen_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        ovf_q   <= ovf_d;
        seen_q  <= seen_d;
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the HTTP response status splitter.
// Feeds byte streams, predicts each status/length result and compares the results.
// Depends on hrss_pkg, hrss_byte_if, hrss_result_if and http_response_status_splitter.
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either channel
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 8;

  typedef enum logic [3:0] {
    LP_PREFIX, LP_MAJOR_FIRST, LP_MAJOR, LP_MINOR_FIRST, LP_MINOR,
    LP_SPACE_SKIP, LP_NEED_DIGIT, LP_DIGITS, LP_DONE, LP_BAD
  } line_phase_e;

  typedef struct packed {
    logic signed [31:0] status;
    logic               has_term;
    logic [31:0]        hdr_bytes;
    logic [31:0]        body_bytes;
  } split_result_t;

  logic clk_i;
  logic rst_ni;

  hrss_byte_if   byte_if ();
  hrss_result_if res_if ();

  http_response_status_splitter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (res_if)
  );

  // Results still to come, oldest first
  split_result_t awaited[$];
  logic [7:0]    tx_bytes[$];

  int mismatch_count = 0;
  int bytes_sent = 0;
  int hold_request = 0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;

  // Predictor state for the response being received
  logic [31:0] rx_pos;
  line_phase_e rx_phase;
  logic [31:0] code_acc;
  logic        code_neg;
  logic        code_ovf;
  logic        code_digit_seen;
  logic [2:0]  crlf_count;
  logic        term_found;
  logic [31:0] term_pos;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void clear_split_state();
    rx_pos          = '0;
    rx_phase        = LP_PREFIX;
    code_acc        = '0;
    code_neg        = 1'b0;
    code_ovf        = 1'b0;
    code_digit_seen = 1'b0;
    crlf_count      = '0;
    term_found      = 1'b0;
    term_pos        = '0;
  endfunction

  // Accumulate one decimal digit, saturating at the largest int
  function automatic void take_digit(input logic [7:0] c);
    logic [31:0] d;
    d = 32'(c - hrss_pkg::CHAR_ZERO);
    code_digit_seen = 1'b1;
    if (code_ovf || code_acc > (hrss_pkg::CODE_MAX - d) / 32'd10) begin
      code_ovf = 1'b1;
      code_acc = hrss_pkg::CODE_MAX;
    end else begin
      code_acc = code_acc * 32'd10 + d;
    end
  endfunction

  // Advance the predicted parse by one accepted byte; queue a result on the last one
  function automatic void predict_byte(input logic [7:0] c, input logic fin);
    logic          is_dig;
    logic          is_ws;
    logic [32:0]   hdr_plus4;
    split_result_t res;
    is_dig = c inside {[hrss_pkg::CHAR_ZERO:hrss_pkg::CHAR_NINE]};
    is_ws  = (c == hrss_pkg::CHAR_SPACE) || (c inside {[8'h09:hrss_pkg::CHAR_CR]});

    // status line
    case (rx_phase)
      LP_PREFIX: begin
        if (rx_pos < hrss_pkg::PREFIX_LEN && c == hrss_pkg::PREFIX_TEXT[rx_pos[2:0]])
          rx_phase = (rx_pos == hrss_pkg::PREFIX_LEN - 1) ? LP_MAJOR_FIRST : LP_PREFIX;
        else
          rx_phase = LP_BAD;
      end
      LP_MAJOR_FIRST: rx_phase = is_dig ? LP_MAJOR : LP_BAD;
      LP_MAJOR: begin
        if (c == hrss_pkg::CHAR_DOT) rx_phase = LP_MINOR_FIRST;
        else if (!is_dig) rx_phase = LP_BAD;
      end
      LP_MINOR_FIRST: rx_phase = is_dig ? LP_MINOR : LP_BAD;
      LP_MINOR: begin
        if (c == hrss_pkg::CHAR_SPACE) rx_phase = LP_SPACE_SKIP;
        else if (!is_dig) rx_phase = LP_BAD;
      end
      LP_SPACE_SKIP: begin
        if (!is_ws) begin
          if (c == hrss_pkg::CHAR_PLUS || c == hrss_pkg::CHAR_MINUS) begin
            code_neg = (c == hrss_pkg::CHAR_MINUS);
            rx_phase = LP_NEED_DIGIT;
          end else if (is_dig) begin
            take_digit(c);
            rx_phase = LP_DIGITS;
          end else begin
            rx_phase = LP_BAD;
          end
        end
      end
      LP_NEED_DIGIT: begin
        if (is_dig) begin
          take_digit(c);
          rx_phase = LP_DIGITS;
        end else begin
          rx_phase = LP_BAD;
        end
      end
      LP_DIGITS: begin
        if (is_dig) take_digit(c);
        else rx_phase = LP_DONE;
      end
      default: ;
    endcase

    // first CR LF CR LF only
    if (!term_found) begin
      if (crlf_count == 3'd3 && c == hrss_pkg::CHAR_LF) begin
        term_found = 1'b1;
        term_pos   = (rx_pos >= 32'd3) ? rx_pos - 32'd3 : '0;
        crlf_count = '0;
      end else if (c == hrss_pkg::CHAR_CR) begin
        crlf_count = (crlf_count == 3'd2) ? 3'd3 : 3'd1;
      end else if (c == hrss_pkg::CHAR_LF && crlf_count == 3'd1) begin
        crlf_count = 3'd2;
      end else begin
        crlf_count = '0;
      end
    end

    if (rx_pos != '1) rx_pos++;

    if (fin) begin
      res.status = '1;
      if (code_digit_seen && !code_ovf && (rx_phase == LP_DIGITS || rx_phase == LP_DONE) &&
          (!code_neg || code_acc == '0))
        res.status = code_acc;
      res.has_term   = term_found;
      res.hdr_bytes  = term_found ? term_pos : '0;
      hdr_plus4      = {1'b0, term_pos} + 33'd4;
      res.body_bytes = (term_found && {1'b0, rx_pos} >= hdr_plus4) ?
                       rx_pos - term_pos - 32'd4 : '0;
      awaited.push_back(res);
      clear_split_state();
    end
  endfunction

  // One byte transfer on the input channel, with an optional idle burst first
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last      <= fin;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    predict_byte(b, fin);
    bytes_sent++;
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endfunction

  function automatic void put_digits(input int n);
    repeat (n) tx_bytes.push_back(8'(hrss_pkg::CHAR_ZERO + $urandom_range(0, 9)));
  endfunction

  // Send the assembled response, marking its final byte
  task automatic ship_response();
    for (int i = 0; i < tx_bytes.size(); i++)
      send_byte(tx_bytes[i], i == tx_bytes.size() - 1);
    tx_bytes.delete();
  endtask

  task automatic ship_text(input string s);
    put_text(s);
    ship_response();
  endtask

  // Stop offering and wait until every awaited result has been taken
  task automatic wait_for_results();
    byte_if.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed responses with random content; some corrupted, some noise
  function automatic void put_random_response();
    int         kind;
    int         n;
    logic [7:0] ws;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    put_text("HTTP/");
    put_digits($urandom_range(1, 2));
    tx_bytes.push_back(hrss_pkg::CHAR_DOT);
    put_digits($urandom_range(1, 2));
    tx_bytes.push_back(hrss_pkg::CHAR_SPACE);
    repeat ($urandom_range(0, 2)) begin
      ws = 8'($urandom_range(8, 13));
      tx_bytes.push_back((ws == 8'h08) ? hrss_pkg::CHAR_SPACE : ws);
    end
    case ($urandom_range(0, 7))
      0: tx_bytes.push_back(hrss_pkg::CHAR_PLUS);
      1: tx_bytes.push_back(hrss_pkg::CHAR_MINUS);
      default: ;
    endcase
    // code: none, overlong, around the int limit, or a usual three digits
    case ($urandom_range(0, 5))
      0: n = 0;
      1: n = $urandom_range(10, 14);
      2: begin
        put_text("214748364");
        n = 1;
      end
      default: n = 3;
    endcase
    put_digits(n);
    if ($urandom_range(0, 1) == 1) put_text(" OK");
    repeat ($urandom_range(0, 2)) begin
      put_text("\015\012X-");
      repeat ($urandom_range(0, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) != 0) put_text("\015\012\015\012");
    repeat ($urandom_range(0, 6)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    if (kind == 1) tx_bytes[$urandom_range(0, tx_bytes.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  // Status line forms, code limits, signs, whitespace and terminator placement
  // (\015 is CR, \012 LF, \013 VT, \014 FF)
  task automatic test_status_line_cases();
    ship_text("HTTP/1.1 200 OK\015\012\015\012hello");
    ship_text("HTTP/1.0 0\015\012\015\012");
    ship_text("HTTP/1.1 2147483647\015\012\015\012");
    ship_text("HTTP/1.1 2147483648");
    ship_text("HTTP/1.1 99999999999999");
    ship_text("HTTP/1.1 -0");
    ship_text("HTTP/1.1 -404 Nope");
    ship_text("HTTP/1.1 +302 Found");
    ship_text("HTTP/1.1 \t\012\013\014\015 7");
    ship_text("HTTP/1.1 -");
    ship_text("HTTP/1.1 + 5");
    ship_text("HTTP/1.1 ");
    ship_text("HTTP/1.1 x200");
    ship_text("HTTP/1.x 200");
    ship_text("HTTPS/1.1 200");
    ship_text("HTTP/.1 200");
    ship_text("HTTP/1. 200");
    ship_text("HTTP/1.1\t200");
    ship_text("HTTP/12.34 201 5 6");
    // NUL ends the digits
    put_text("HTTP/1.1 204");
    tx_bytes.push_back(8'h00);
    ship_text("5");
    ship_text("\015\012\015\012");
    ship_text("HTTP/1.1 200\015\012\015\012A\015\012\015\012B");
    ship_text("\015\015\012\015\012\015\012\015\015\012\015\012xy");
    tx_bytes.push_back(8'hff);
    ship_response();
    wait_for_results();
  endtask

  task automatic test_random_responses();
    int goal;
    goal = bytes_sent + 400;
    while (bytes_sent < goal) begin
      put_random_response();
      ship_response();
    end
    wait_for_results();
  endtask

  // Result side holds off while responses keep coming, so the input stalls
  task automatic test_result_backpressure();
    hold_request = LONG_HOLD;
    repeat (4) begin
      put_random_response();
      ship_response();
    end
    wait_for_results();
  endtask

  task automatic test_full_rate();
    int goal;
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    goal = bytes_sent + 250;
    while (bytes_sent < goal) begin
      put_random_response();
      ship_response();
    end
    wait_for_results();
  endtask

  // Result side: check each transfer, then pick ready for the next cycle
  initial begin : result_sink
    int            stall_left;
    int            hold_left;
    split_result_t want;
    stall_left = 0;
    hold_left  = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (awaited.size() == 0) begin
          report_mismatch("result with none awaited");
        end else begin
          want = awaited.pop_front();
          if (res_if.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", res_if.status, want.status));
          if (res_if.has_terminator !== want.has_term)
            report_mismatch($sformatf("has_terminator got %0b want %0b",
                                      res_if.has_terminator, want.has_term));
          if (res_if.header_length !== want.hdr_bytes)
            report_mismatch($sformatf("header_length got %0d want %0d",
                                      res_if.header_length, want.hdr_bytes));
          if (res_if.body_length !== want.body_bytes)
            report_mismatch($sformatf("body_length got %0d want %0d",
                                      res_if.body_length, want.body_bytes));
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout after %0d quiet cycles", quiet);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni            <= 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.last      <= 1'b0;
    clear_split_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_status_line_cases();
    test_random_responses();
    test_result_backpressure();
    test_full_rate();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
